/* rtl/ssdcwb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssdcwb_pkg: shared types and constants of the command write buffer
// Command and status codes, default widths and the per-cell control bundle.
// ---------------------------------------------------------------------------
package ssdcwb_pkg;

    // Default sizing
    localparam int DEPTH_DEF     = 16;
    localparam int LBA_BITS_DEF  = 10;
    localparam int DATA_BITS_DEF = 32;

    // Fixed field widths
    localparam int CMD_BITS    = 2;
    localparam int SIZE_BITS   = 8;
    localparam int STATUS_BITS = 2;

    // Host command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // Control into one buffer cell
    typedef struct packed {
        logic shift;  // take the neighbor's entry
        logic load;   // take a new entry from the host
    } cell_ctrl_t;

endpackage

/* rtl/ssdcwb_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssdcwb_cell: one buffer slot of the entry chain
// Holds one write or erase entry; loads a new entry or takes its neighbor's.
// ---------------------------------------------------------------------------
module ssdcwb_cell #(
    parameter int LBA_BITS  = ssdcwb_pkg::LBA_BITS_DEF,
    parameter int DATA_BITS = ssdcwb_pkg::DATA_BITS_DEF
) (
    input  logic                           clk,
    input  ssdcwb_pkg::cell_ctrl_t         ctrl,
    // entry from the neighbor cell
    input  logic                           nb_is_erase,
    input  logic [LBA_BITS-1:0]            nb_lba,
    input  logic [ssdcwb_pkg::SIZE_BITS-1:0] nb_size,
    input  logic [DATA_BITS-1:0]           nb_data,
    // entry from the host
    input  logic                           ld_is_erase,
    input  logic [LBA_BITS-1:0]            ld_lba,
    input  logic [ssdcwb_pkg::SIZE_BITS-1:0] ld_size,
    input  logic [DATA_BITS-1:0]           ld_data,
    // held entry
    output logic                           is_erase,
    output logic [LBA_BITS-1:0]            slot_lba,
    output logic [ssdcwb_pkg::SIZE_BITS-1:0] slot_size,
    output logic [DATA_BITS-1:0]           slot_data
);
    import ssdcwb_pkg::*;

    logic                 is_erase_reg;
    logic [LBA_BITS-1:0]  lba_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [DATA_BITS-1:0] data_reg;

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            is_erase_reg <= ld_is_erase;
            lba_reg      <= ld_lba;
            size_reg     <= ld_size;
            data_reg     <= ld_data;
        end
        else if (ctrl.shift)
        begin
            is_erase_reg <= nb_is_erase;
            lba_reg      <= nb_lba;
            size_reg     <= nb_size;
            data_reg     <= nb_data;
        end
    end

    assign is_erase  = is_erase_reg;
    assign slot_lba  = lba_reg;
    assign slot_size = size_reg;
    assign slot_data = data_reg;

endmodule

/* rtl/ssd_command_write_buffer_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssd_command_write_buffer_unit: write buffer with read forwarding
// Holds write and erase commands in arrival order in a ring of cells, answers
// reads from the newest covering entry and drains the buffer on a flush.
// ---------------------------------------------------------------------------
// Sequence: a write or erase is stored at once and its result is valid in
// the cycle after it is taken. A read rotates the cell ring one full turn
// past a single compare unit at the head, oldest entry first, and then sends
// the result. A flush shifts the head entry out, one per cycle while the
// result channel is free; an empty buffer gives one EMPTY result. Only one
// command is in progress at a time; the next is taken once the current one
// has sent its last result. Buffer storage has no reset; the fill count
// alone says which cells hold entries.
module ssd_command_write_buffer_unit #(
    parameter int DEPTH     = ssdcwb_pkg::DEPTH_DEF,
    parameter int LBA_BITS  = ssdcwb_pkg::LBA_BITS_DEF,
    parameter int DATA_BITS = ssdcwb_pkg::DATA_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ssdcwb_pkg::CMD_BITS-1:0]    command,
    input  logic [LBA_BITS-1:0]                lba,
    input  logic [DATA_BITS-1:0]               write_data,
    input  logic [ssdcwb_pkg::SIZE_BITS-1:0]   erase_size,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ssdcwb_pkg::STATUS_BITS-1:0] status,
    output logic                               hit,
    output logic [DATA_BITS-1:0]               read_data,
    output logic                               entry_is_erase,
    output logic [LBA_BITS-1:0]                entry_lba,
    output logic [ssdcwb_pkg::SIZE_BITS-1:0]   entry_size,
    output logic [DATA_BITS-1:0]               entry_data,
    output logic                               last,
    output logic [$clog2(DEPTH+1)-1:0]         entry_count
);
    import ssdcwb_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (LBA_BITS > SIZE_BITS) ? LBA_BITS : SIZE_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;

    // Read scan state
    logic [LBA_BITS-1:0]  scan_lba_reg, scan_lba_next;
    logic                 scan_hit_reg, scan_hit_next;
    logic [DATA_BITS-1:0] scan_data_reg, scan_data_next;

    // Result payload
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   hit_reg, hit_next;
    logic [DATA_BITS-1:0]   rdata_reg, rdata_next;
    logic                   e_erase_reg, e_erase_next;
    logic [LBA_BITS-1:0]    e_lba_reg, e_lba_next;
    logic [SIZE_BITS-1:0]   e_size_reg, e_size_next;
    logic [DATA_BITS-1:0]   e_data_reg, e_data_next;
    logic                   last_reg, last_next;
    logic [CW-1:0]          count_reg, count_next;

    // Cell ring
    logic                 c_erase [DEPTH];
    logic [LBA_BITS-1:0]  c_lba   [DEPTH];
    logic [SIZE_BITS-1:0] c_size  [DEPTH];
    logic [DATA_BITS-1:0] c_data  [DEPTH];
    cell_ctrl_t           c_ctrl  [DEPTH];

    logic                 ring_shift;
    logic                 host_load;
    logic                 ld_erase;
    logic [SIZE_BITS-1:0] ld_size;
    logic [DATA_BITS-1:0] ld_data;

    logic                 out_free;
    logic                 accept;
    logic                 emit;
    logic [LBA_BITS-1:0]  head_diff;
    logic [CMPW-1:0]      diff_ext;
    logic [CMPW-1:0]      size_ext;
    logic                 head_covers;
    logic                 flush_last;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    // Host entry, erase keeps size and zero data, write keeps data
    assign ld_erase = (command == CMD_ERASE);
    assign ld_size  = ld_erase ? erase_size : '0;
    assign ld_data  = ld_erase ? '0 : write_data;

    // Ring of cells, each takes the next one's entry; the head wraps to the tail
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        localparam int NB = (k + 1) % DEPTH;

        assign c_ctrl[k].shift = ring_shift;
        assign c_ctrl[k].load  = host_load && (fill_reg == CW'(k));

        ssdcwb_cell #(
            .LBA_BITS  (LBA_BITS),
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (c_ctrl[k]),
            .nb_is_erase (c_erase[NB]),
            .nb_lba      (c_lba[NB]),
            .nb_size     (c_size[NB]),
            .nb_data     (c_data[NB]),
            .ld_is_erase (ld_erase),
            .ld_lba      (lba),
            .ld_size     (ld_size),
            .ld_data     (ld_data),
            .is_erase    (c_erase[k]),
            .slot_lba    (c_lba[k]),
            .slot_size   (c_size[k]),
            .slot_data   (c_data[k])
        );
    end

    // Coverage test of the head entry against the read address
    assign head_diff = scan_lba_reg - c_lba[0];
    assign diff_ext  = CMPW'(head_diff);
    assign size_ext  = CMPW'(c_size[0]);
    assign head_covers = c_erase[0]
                       ? ((scan_lba_reg >= c_lba[0]) && (diff_ext < size_ext))
                       : (scan_lba_reg == c_lba[0]);

    assign flush_last = ((step_reg + CW'(1)) == fill_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        step_next      = step_reg;
        scan_lba_next  = scan_lba_reg;
        scan_hit_next  = scan_hit_reg;
        scan_data_next = scan_data_reg;
        ring_shift     = 1'b0;
        host_load      = 1'b0;
        emit           = 1'b0;

        status_next  = ST_OK;
        hit_next     = 1'b0;
        rdata_next   = '0;
        e_erase_next = 1'b0;
        e_lba_next   = '0;
        e_size_next  = '0;
        e_data_next  = '0;
        last_next    = 1'b1;
        count_next   = fill_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_READ:
                        begin
                            scan_lba_next  = lba;
                            scan_hit_next  = 1'b0;
                            scan_data_next = '0;
                            step_next      = '0;
                            state_next     = S_SCAN;
                        end
                        CMD_WRITE, CMD_ERASE:
                        begin
                            emit = 1'b1;
                            if (fill_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                host_load  = 1'b1;
                                fill_next  = fill_reg + CW'(1);
                                count_next = fill_reg + CW'(1);
                            end
                        end
                        CMD_FLUSH:
                        begin
                            if (fill_reg == '0)
                            begin
                                emit        = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                step_next  = '0;
                                state_next = S_FLUSH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (step_reg != CW'(DEPTH))
                begin
                    // one entry per cycle, oldest first, so the newest hit stays
                    ring_shift = 1'b1;
                    step_next  = step_reg + CW'(1);
                    if ((step_reg < fill_reg) && head_covers)
                    begin
                        scan_hit_next  = 1'b1;
                        scan_data_next = c_erase[0] ? '0 : c_data[0];
                    end
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    hit_next   = scan_hit_reg;
                    rdata_next = scan_data_reg;
                    state_next = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    ring_shift   = 1'b1;
                    e_erase_next = c_erase[0];
                    e_lba_next   = c_lba[0];
                    e_size_next  = c_size[0];
                    e_data_next  = c_data[0];
                    last_next    = flush_last;
                    count_next   = '0;
                    step_next    = step_reg + CW'(1);
                    if (flush_last)
                    begin
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan and result payload
    always_ff @(posedge clk)
    begin
        scan_lba_reg  <= scan_lba_next;
        scan_hit_reg  <= scan_hit_next;
        scan_data_reg <= scan_data_next;
        if (emit)
        begin
            status_reg  <= status_next;
            hit_reg     <= hit_next;
            rdata_reg   <= rdata_next;
            e_erase_reg <= e_erase_next;
            e_lba_reg   <= e_lba_next;
            e_size_reg  <= e_size_next;
            e_data_reg  <= e_data_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
        end
    end

    // Outputs
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign hit            = hit_reg;
    assign read_data      = rdata_reg;
    assign entry_is_erase = e_erase_reg;
    assign entry_lba      = e_lba_reg;
    assign entry_size     = e_size_reg;
    assign entry_data     = e_data_reg;
    assign last           = last_reg;
    assign entry_count    = count_reg;

endmodule
